@@ hw/rtl/pcc_pkg.sv @@
// Shared types and constants for the clamped PI controller.
package pcc_pkg;

  localparam int TIME_STEP_WIDTH = 16;
  localparam int GAIN_WIDTH      = 16;
  localparam int LIMIT_WIDTH     = 15;
  localparam int DRIVE_WIDTH     = 16;
  localparam int INTEG_WIDTH     = 32;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam logic [GAIN_WIDTH-1:0]  PROP_GAIN_RESET    = 16'd256;
  localparam logic [GAIN_WIDTH-1:0]  INTEG_GAIN_RESET   = 16'd256;
  localparam logic [LIMIT_WIDTH-1:0] OUTPUT_LIMIT_RESET = 15'd4800;

  localparam logic MODE_REGULAR   = 1'b0;
  localparam logic MODE_IRREGULAR = 1'b1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_OUTPUT_LIMIT,
    REG_INTERVAL_MODE
  } pcc_reg_t;

  typedef struct packed {
    logic [GAIN_WIDTH-1:0]  prop_gain;
    logic [GAIN_WIDTH-1:0]  integ_gain;
    logic [LIMIT_WIDTH-1:0] output_limit;
    logic                   interval_mode;
  } pcc_cfg_t;

endpackage

@@ hw/rtl/pcc_integ.sv @@
// Running integral register with truncation, limit clamp and 32-bit saturation.
module pcc_integ
  import pcc_pkg::*;
#(
  parameter int ERROR_WIDTH    = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  en,
  input  pcc_cfg_t                                              cfg,
  input  logic signed [ERROR_WIDTH+TIME_STEP_WIDTH:0]           product,
  output logic signed [INTEG_WIDTH-1:0]                         integ
);

  localparam int PW = ERROR_WIDTH + TIME_STEP_WIDTH + 1;
  localparam int AW = ((PW > INTEG_WIDTH) ? PW : INTEG_WIDTH) + 2;
  localparam logic [PW-1:0] FRAC_MASK = PW'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
  localparam logic signed [AW-1:0] SAT_HI =
    {{(AW-INTEG_WIDTH+1){1'b0}}, {(INTEG_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO =
    {{(AW-INTEG_WIDTH+1){1'b1}}, {(INTEG_WIDTH-1){1'b0}}};

  logic signed [PW-1:0]          prod_shift;
  logic signed [AW-1:0]          addend;
  logic signed [AW-1:0]          floor_sum;
  logic signed [AW-1:0]          trunc_sum;
  logic signed [AW-1:0]          lim_s;
  logic signed [AW-1:0]          bound_hi;
  logic signed [AW-1:0]          bound_lo;
  logic signed [AW-1:0]          clipped;
  logic                          frac_nz;
  logic                          round_up;
  logic signed [INTEG_WIDTH-1:0] integ_next;

  // In regular mode the gain product carries the fraction bits; the integer part
  // is added here and truncation toward zero is restored by the round-up bit.
  always_comb begin
    prod_shift = product >>> GAIN_FRAC_BITS;
    addend     = (cfg.interval_mode == MODE_IRREGULAR) ? AW'(product) : AW'(prod_shift);
    floor_sum  = AW'(integ) + addend;
    frac_nz    = |(product & FRAC_MASK);
    round_up   = (cfg.interval_mode == MODE_REGULAR) && floor_sum[AW-1] && frac_nz;
    trunc_sum  = floor_sum + $signed({{(AW-1){1'b0}}, round_up});
    lim_s      = $signed({{(AW-LIMIT_WIDTH){1'b0}}, cfg.output_limit});
    bound_hi   = (cfg.interval_mode == MODE_IRREGULAR) ? SAT_HI : lim_s;
    bound_lo   = (cfg.interval_mode == MODE_IRREGULAR) ? SAT_LO : -lim_s;
    if (trunc_sum > bound_hi) begin
      clipped = bound_hi;
    end else if (trunc_sum < bound_lo) begin
      clipped = bound_lo;
    end else begin
      clipped = trunc_sum;
    end
    integ_next = clipped[INTEG_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
    end else if (en) begin
      integ <= integ_next;
    end
  end

  // After a regular-mode update the integral lies within the output limit.
  assert property (@(posedge clk) disable iff (rst)
    en && (cfg.interval_mode == MODE_REGULAR) |=>
      (integ <= $signed({{(INTEG_WIDTH-LIMIT_WIDTH){1'b0}}, cfg.output_limit})) &&
      (integ >= -$signed({{(INTEG_WIDTH-LIMIT_WIDTH){1'b0}}, cfg.output_limit})))
    else $error("integral outside limit after regular update");

  // A zero increment in irregular mode leaves the integral untouched.
  assert property (@(posedge clk) disable iff (rst)
    en && (cfg.interval_mode == MODE_IRREGULAR) && (product == '0) |=>
      integ == $past(integ))
    else $error("integral changed on zero irregular increment");

endmodule

@@ hw/rtl/pi_controller_clamped_unit.sv @@
// Top level of the clamped PI controller: config registers and the datapath pipeline.
// Each result passes through the input register, gain products, integral update, integral term, scaled sum and output.
// Throughput: one item per cycle while m_tready does not stall the output; the integral is
// updated in a single stage, so items may follow each other back to back.
// Backpressure on m_tready holds the whole pipeline, which shows on s_tready.
// Reset empties the pipeline, zeroes the integral and restores the register defaults.
module pi_controller_clamped_unit
  import pcc_pkg::*;
#(
  parameter int ERROR_WIDTH    = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // error_sample, time_step, zero padding
  input  logic [((ERROR_WIDTH+TIME_STEP_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // drive
  output logic [DRIVE_WIDTH-1:0]              m_tdata,
  // clamped
  output logic [0:0]                          m_tuser,
  input  logic                                cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]          cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]           cfg_data
);

  localparam int PW = ERROR_WIDTH + TIME_STEP_WIDTH + 1;
  localparam int TW = INTEG_WIDTH + GAIN_WIDTH + 1;
  localparam int SW = ((TW > PW) ? TW : PW) + 1;
  localparam logic [SW-1:0] FRAC_MASK = SW'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  pcc_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain     <= PROP_GAIN_RESET;
      cfg.integ_gain    <= INTEG_GAIN_RESET;
      cfg.output_limit  <= OUTPUT_LIMIT_RESET;
      cfg.interval_mode <= MODE_REGULAR;
    end else if (cfg_we) begin
      unique case (pcc_reg_t'(cfg_index))
        REG_PROP_GAIN:     cfg.prop_gain     <= cfg_data[GAIN_WIDTH-1:0];
        REG_INTEG_GAIN:    cfg.integ_gain    <= cfg_data[GAIN_WIDTH-1:0];
        REG_OUTPUT_LIMIT:  cfg.output_limit  <= cfg_data[LIMIT_WIDTH-1:0];
        REG_INTERVAL_MODE: cfg.interval_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic       adv;
  logic [4:0] vld;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vld      <= {vld[3:0], s_tvalid};
      m_tvalid <= vld[4];
    end
  end

  // Stage 0: input register.
  logic signed [ERROR_WIDTH-1:0]  err0;
  logic [TIME_STEP_WIDTH-1:0]     ts0;

  // Stage 1: the two gain products.
  logic signed [PW-1:0] err_ext;
  logic signed [PW-1:0] int_factor;
  logic signed [PW-1:0] kp_factor;
  logic signed [PW-1:0] int_prod1;
  logic signed [PW-1:0] kp_prod1;

  // Stage 2: integral update; the integral register is this stage's value.
  logic signed [PW-1:0]          kp_prod2;
  logic signed [INTEG_WIDTH-1:0] integ;

  // Stage 3: integral term at the gain scale.
  logic signed [TW-1:0] integ_ext;
  logic signed [TW-1:0] ki_ext;
  logic signed [TW-1:0] term3;
  logic signed [PW-1:0] kp_prod3;

  // Stage 4: scaled sum; stage 5: truncation, clamp and output register.
  logic signed [SW-1:0] sum4;
  logic signed [SW-1:0] biased;
  logic signed [SW-1:0] quot;
  logic signed [SW-1:0] lim_s;
  logic signed [SW-1:0] drive_next;
  logic                 hit_next;

  always_comb begin
    err_ext    = PW'(err0);
    int_factor = (cfg.interval_mode == MODE_IRREGULAR) ?
                 $signed(PW'({1'b0, ts0})) : $signed(PW'({1'b0, cfg.integ_gain}));
    kp_factor  = $signed(PW'({1'b0, cfg.prop_gain}));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err0      <= s_tdata[ERROR_WIDTH-1:0];
      ts0       <= s_tdata[ERROR_WIDTH +: TIME_STEP_WIDTH];
      int_prod1 <= err_ext * int_factor;
      kp_prod1  <= err_ext * kp_factor;
      kp_prod2  <= kp_prod1;
      kp_prod3  <= kp_prod2;
      term3     <= (cfg.interval_mode == MODE_IRREGULAR) ?
                   integ_ext * ki_ext : integ_ext <<< GAIN_FRAC_BITS;
      sum4      <= SW'(term3) + SW'(kp_prod3);
      m_tdata   <= drive_next[DRIVE_WIDTH-1:0];
      m_tuser   <= hit_next;
    end
  end

  pcc_integ #(
    .ERROR_WIDTH   (ERROR_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_integ (
    .clk    (clk),
    .rst    (rst),
    .en     (adv && vld[1]),
    .cfg    (cfg),
    .product(int_prod1),
    .integ  (integ)
  );

  // Adding the fraction mask before the arithmetic shift turns the floor into
  // truncation toward zero for negative sums.
  always_comb begin
    integ_ext = TW'(integ);
    ki_ext    = $signed(TW'({1'b0, cfg.integ_gain}));
    biased    = sum4 + (sum4[SW-1] ? $signed(FRAC_MASK) : $signed(SW'(0)));
    quot      = biased >>> GAIN_FRAC_BITS;
    lim_s     = $signed({{(SW-LIMIT_WIDTH){1'b0}}, cfg.output_limit});
    hit_next  = 1'b1;
    if (quot > lim_s) begin
      drive_next = lim_s;
    end else if (quot < -lim_s) begin
      drive_next = -lim_s;
    end else begin
      drive_next = quot;
      hit_next   = 1'b0;
    end
  end

  // The drive never leaves the symmetric limit.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      ($signed(m_tdata) <= $signed({1'b0, cfg.output_limit})) &&
      ($signed(m_tdata) >= -$signed({1'b0, cfg.output_limit})))
    else $error("drive outside output limit");

  // A clamped result sits exactly on one of the two bounds.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      ($signed(m_tdata) == $signed({1'b0, cfg.output_limit})) ||
      ($signed(m_tdata) == -$signed({1'b0, cfg.output_limit})))
    else $error("clamped flag set with drive off the bound");

endmodule

@@ verif/tb_pi_controller_clamped_unit.sv @@
// Self-checking testbench for the clamped PI controller: directed and random samples.
module tb_pi_controller_clamped_unit;
  import pcc_pkg::*;

  localparam int FRAC_BITS   = 8;
  localparam int LATENCY     = 5;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 85;

  typedef struct packed {
    logic [DRIVE_WIDTH-1:0] drive;
    logic                   clamped;
  } drive_result_t;

  // Tracks the controller state and configuration and holds the drives still to come.
  class pi_scoreboard;
    logic [GAIN_WIDTH-1:0]  prop_gain;
    logic [GAIN_WIDTH-1:0]  integ_gain;
    logic [LIMIT_WIDTH-1:0] output_limit;
    logic                   interval_mode;
    logic signed [INTEG_WIDTH-1:0] integral;
    drive_result_t expected_drives[$];
    int error_count;

    function new();
      prop_gain     = PROP_GAIN_RESET;
      integ_gain    = INTEG_GAIN_RESET;
      output_limit  = OUTPUT_LIMIT_RESET;
      interval_mode = MODE_REGULAR;
      integral      = '0;
      error_count   = 0;
    endfunction

    function void set_reg(pcc_reg_t idx, logic [CFG_DATA_WIDTH-1:0] value);
      case (idx)
        REG_PROP_GAIN:     prop_gain     = value[GAIN_WIDTH-1:0];
        REG_INTEG_GAIN:    integ_gain    = value[GAIN_WIDTH-1:0];
        REG_OUTPUT_LIMIT:  output_limit  = value[LIMIT_WIDTH-1:0];
        REG_INTERVAL_MODE: interval_mode = value[0];
        default: ;
      endcase
    endfunction

    // Advances the integral for one accepted sample and queues the drive it leads to.
    function void accept_sample(logic signed [15:0] err, logic [TIME_STEP_WIDTH-1:0] tstep);
      longint e, ts, lim, kp, ki, one, acc, raw, drv;
      logic hit;
      e   = err;
      ts  = tstep;
      lim = output_limit;
      kp  = prop_gain;
      ki  = integ_gain;
      one = longint'(1) << FRAC_BITS;
      if (interval_mode == MODE_REGULAR) begin
        acc = (longint'(integral) * one + ki * e) / one;
        if (acc > lim) acc = lim;
        else if (acc < -lim) acc = -lim;
        integral = acc[INTEG_WIDTH-1:0];
        raw = (kp * e + acc * one) / one;
      end else begin
        acc = longint'(integral) + e * ts;
        if (acc > longint'(32'sh7FFF_FFFF)) acc = 32'sh7FFF_FFFF;
        else if (acc < -longint'(32'sh7FFF_FFFF) - 1) acc = -longint'(32'sh7FFF_FFFF) - 1;
        integral = acc[INTEG_WIDTH-1:0];
        raw = (kp * e + ki * acc) / one;
      end
      hit = 1'b0;
      if (raw > lim) begin
        drv = lim;
        hit = 1'b1;
      end else if (raw < -lim) begin
        drv = -lim;
        hit = 1'b1;
      end else begin
        drv = raw;
      end
      expected_drives.push_back('{drive: drv[DRIVE_WIDTH-1:0], clamped: hit});
    endfunction

    function void check_drive(logic [DRIVE_WIDTH-1:0] drive, logic clamped);
      drive_result_t want;
      if (expected_drives.size() == 0) begin
        $error("unexpected result: drive %0d clamped %0d", $signed(drive), clamped);
        error_count++;
        return;
      end
      want = expected_drives.pop_front();
      if (drive !== want.drive) begin
        $error("drive: expected %0d, actual %0d", $signed(want.drive), $signed(drive));
        error_count++;
      end
      if (clamped !== want.clamped) begin
        $error("clamped: expected %0d, actual %0d", want.clamped, clamped);
        error_count++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [DRIVE_WIDTH-1:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we;
  pcc_reg_t    cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_data;

  pi_scoreboard sb;
  int burst_left;
  bit hold_request;
  int rx_count;
  int rx_kind;
  int idle_cycles;

  pi_controller_clamped_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one sample, opening a new burst after a random gap when the current one is used up.
  task automatic offer(input logic signed [15:0] err, input logic [15:0] tstep);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        s_tdata  <= $urandom;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {tstep, err};
    do @(posedge clk); while (!s_tready);
    sb.accept_sample(err, tstep);
  endtask

  task automatic wait_drained();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (sb.expected_drives.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input pcc_reg_t idx, input logic [CFG_DATA_WIDTH-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // Registers change only once every outstanding drive has come back.
  task automatic apply_settings(input logic [15:0] kp, input logic [15:0] ki,
                                input logic [15:0] lim, input logic [15:0] mode);
    wait_drained();
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_OUTPUT_LIMIT, lim);
    write_reg(REG_INTERVAL_MODE, mode);
    cfg_we   <= 1'b0;
    cfg_data <= CFG_DATA_WIDTH'($urandom);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd256;
      3:       return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_error();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sd0;
          3:       return 16'sd1;
          default: return -16'sd1;
        endcase
      end
      1, 2:    return 16'($signed($urandom_range(0, 128)) - 64);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 15))
      0:          return 16'd0;
      1:          return 16'hFFFF;
      2, 3, 4, 5: return 16'($urandom_range(1, 16));
      default:    return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Receiver: randomly chosen stall patterns, with one long hold on request.
  initial begin
    m_tready <= 1'b0;
    rx_count = 0;
    rx_kind  = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_drive(m_tdata, m_tuser[0]);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (rx_count % 48 == 0) rx_kind = $urandom_range(0, 3);
      rx_count++;
      case (rx_kind)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        2:       m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= rx_count[0];
      endcase
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("pi_controller_clamped_unit: mismatch");
    $finish;
  end

  initial begin
    logic [15:0] kp, ki, lim, mode;
    sb = new();
    burst_left   = 0;
    hold_request = 1'b0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_PROP_GAIN;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: regular mode, unity gains, limit of 4800.
    offer(16'sh7FFF, 16'd1);
    offer(16'sh8000, 16'hFFFF);
    offer(16'sd0, 16'd0);
    offer(16'sd1, 16'd1);
    offer(-16'sd1, 16'hFFFF);
    offer(16'sh7FFF, 16'h5555);
    offer(16'sh8000, 16'hAAAA);

    // Irregular mode: a zero time step, then drive the integral into both 32-bit bounds.
    apply_settings(16'd256, 16'd1, 16'd32767, {15'd0, MODE_IRREGULAR});
    offer(16'sd1000, 16'd0);
    repeat (3) offer(16'sh7FFF, 16'hFFFF);
    repeat (5) offer(16'sh8000, 16'hFFFF);

    // Back to regular mode with the integral still at its negative bound.
    apply_settings(16'd256, 16'd1, 16'd32767, {15'd0, MODE_REGULAR});
    offer(16'sd0, 16'd1);
    offer(16'sd5, 16'd1);

    // A zero limit pins the drive at zero in both modes.
    apply_settings(16'hFFFF, 16'hFFFF, 16'd0, {15'd0, MODE_REGULAR});
    offer(16'sh7FFF, 16'd1);
    offer(16'sh8000, 16'd1);
    offer(16'sd0, 16'd1);
    apply_settings(16'hFFFF, 16'hFFFF, 16'd0, {15'd0, MODE_IRREGULAR});
    offer(-16'sd100, 16'd300);
    offer(16'sd100, 16'd1);

    apply_settings(16'hFFFF, 16'hFFFF, 16'd32767, {15'd0, MODE_REGULAR});
    offer(16'sh7FFF, 16'd1);
    offer(16'sh8000, 16'd1);

    for (int p = 0; p < RAND_PHASES; p++) begin
      kp = pick_gain();
      ki = pick_gain();
      case ($urandom_range(0, 4))
        0:       lim = 16'd0;
        1:       lim = 16'h7FFF;
        2:       lim = 16'($urandom_range(1, 200));
        default: lim = 16'($urandom_range(0, 32767));
      endcase
      // Upper bits beyond a register's width are set at random and must be dropped.
      lim[15] = 1'($urandom_range(0, 1));
      mode = {15'($urandom), (p % 3 == 0) ? MODE_IRREGULAR : 1'($urandom_range(0, 1))};
      apply_settings(kp, ki, lim, mode);
      if (p == 2) hold_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) offer(pick_error(), pick_step());
    end

    wait_drained();
    repeat (4 * LATENCY) @(posedge clk);
    if (sb.error_count == 0 && sb.expected_drives.size() == 0) begin
      $display("pi_controller_clamped_unit: match");
    end else begin
      $display("pi_controller_clamped_unit: mismatch");
    end
    $finish;
  end

endmodule
